>>> hw/rtl/islc_pkg.sv
// Shared types, constants and helper functions for the infrared slotted link controller.
// Used by every RTL file of the block but islc_ram; depends on nothing.
package islc_pkg;

    // FIFO sizing and line timing.
    localparam int RX_DEPTH      = 64;
    localparam int TX_DEPTH      = 64;
    localparam int BITS_PER_BYTE = 10;

    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

    // Frame length register and its clamp.
    localparam int FRAME_W   = 7;
    localparam int MAX_FRAME = 64;
    localparam int BURST_W   = 7;
    localparam int BURST_CMP_W = (TX_CNT_W > FRAME_W) ? TX_CNT_W : FRAME_W;

    localparam int SLOT_W  = 11;
    localparam int LEVEL_W = 7;
    localparam int BYTE_W  = 8;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FRAME_LENGTH = 1'b0;
    localparam logic REG_MASTER_MODE  = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_LENGTH_RESET = FRAME_W'(16);
    localparam logic               MASTER_MODE_RESET  = 1'b1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_EVENT = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        LM_IDLE  = 2'd0,
        LM_WAIT  = 2'd1,
        LM_BREAK = 2'd2,
        LM_DATA  = 2'd3
    } t_link_mode;

    typedef struct packed {
        logic [1:0]        action;
        logic              idle_seen;
        logic              break_seen;
        logic              rx_ready;
        logic              framing_error;
        logic              tx_empty;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] wr_byte;
    } t_in_item;

    typedef struct packed {
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               send_break;
        logic               notify;
        logic               irq_request;
        logic               write_accepted;
        logic               rd_valid;
        logic [BYTE_W-1:0]  rd_byte;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
    } t_out_item;

    // Configuration seen by the link controller.
    typedef struct packed {
        logic [FRAME_W-1:0] frame_length;
        logic               master_mode;
        logic               master_wr;
    } t_cfg;

    // Everything of a result except the bytes that still come out of the stores.
    typedef struct packed {
        logic               tx_valid;
        logic               tx_pop;
        logic               send_break;
        logic               notify;
        logic               irq_request;
        logic               write_accepted;
        logic               rd_valid;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
    } t_ctl_res;

    typedef struct packed {
        logic                we;
        logic [RX_PTR_W-1:0] waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [RX_PTR_W-1:0] raddr;
    } t_rx_req;

    typedef struct packed {
        logic                we;
        logic [TX_PTR_W-1:0] waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [TX_PTR_W-1:0] raddr;
    } t_tx_req;

    // Frame length clamped to 1..MAX_FRAME.
    function automatic logic [FRAME_W-1:0] eff_width(input logic [FRAME_W-1:0] fl);
        logic [FRAME_W-1:0] w;
        w = fl;
        if (fl == '0) begin
            w = FRAME_W'(1);
        end else if (fl > FRAME_W'(MAX_FRAME)) begin
            w = FRAME_W'(MAX_FRAME);
        end
        return w;
    endfunction

    // Slot period in bit ticks for the given clamped width.
    function automatic logic [SLOT_W-1:0] slot_period(input logic [FRAME_W-1:0] w,
                                                      input logic master);
        logic [SLOT_W-1:0] p;
        if (master) begin
            p = (SLOT_W'(w) + SLOT_W'(2)) * SLOT_W'(2 * BITS_PER_BYTE);
        end else begin
            p = (SLOT_W'(w) + SLOT_W'(1)) * SLOT_W'(BITS_PER_BYTE);
        end
        return p;
    endfunction

endpackage

>>> hw/rtl/islc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; the byte FIFOs of the link controller are built on it.
module islc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/islc_link_ctl.sv
// Link control of the infrared slotted link controller: slot timer, link mode, burst state
// and FIFO pointers, plus the store accesses of each item. Depends on islc_pkg.
module islc_link_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  islc_pkg::t_in_item  i_item,
    input  islc_pkg::t_cfg      i_cfg,
    output islc_pkg::t_ctl_res  o_res,
    output islc_pkg::t_rx_req   o_rx_req,
    output islc_pkg::t_tx_req   o_tx_req
);

    islc_pkg::t_link_mode                 r_link_mode, n_link_mode;
    logic [islc_pkg::BURST_W-1:0]         r_burst_left, n_burst_left;
    logic                                 r_burst_on, n_burst_on;
    logic                                 r_timer_run, n_timer_run;
    logic [islc_pkg::SLOT_W-1:0]          r_slot_count, n_slot_count;
    logic [islc_pkg::RX_PTR_W-1:0]        r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [islc_pkg::TX_PTR_W-1:0]        r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [islc_pkg::RX_CNT_W-1:0]        r_rx_count, n_rx_count;
    logic [islc_pkg::TX_CNT_W-1:0]        r_tx_count, n_tx_count;

    islc_pkg::t_ctl_res res;
    islc_pkg::t_rx_req  rx_req;
    islc_pkg::t_tx_req  tx_req;

    always_comb begin
        logic [islc_pkg::FRAME_W-1:0]     w;
        logic [islc_pkg::SLOT_W-1:0]      period;
        logic [islc_pkg::SLOT_W-1:0]      cnt_inc;
        logic                             ev;
        logic [islc_pkg::BURST_CMP_W-1:0] cnt_cmp;
        logic [islc_pkg::BURST_CMP_W-1:0] w_cmp;

        n_link_mode  = r_link_mode;
        n_burst_left = r_burst_left;
        n_burst_on   = r_burst_on;
        n_timer_run  = r_timer_run;
        n_slot_count = r_slot_count;
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        n_rx_count   = r_rx_count;
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_count   = r_tx_count;
        res          = '0;
        rx_req       = '0;
        tx_req       = '0;
        ev           = 1'b0;

        w       = islc_pkg::eff_width(i_cfg.frame_length);
        period  = islc_pkg::slot_period(w, i_cfg.master_mode);
        cnt_inc = r_slot_count + islc_pkg::SLOT_W'(1);
        cnt_cmp = islc_pkg::BURST_CMP_W'(r_tx_count);
        w_cmp   = islc_pkg::BURST_CMP_W'(w);

        case (islc_pkg::t_action'(i_item.action))
            islc_pkg::ACT_TICK: begin
                if (r_timer_run) begin
                    if (cnt_inc >= period) begin
                        n_slot_count = '0;
                        if (i_cfg.master_mode || (r_tx_count != '0)) begin
                            res.send_break = 1'b1;
                            n_link_mode    = islc_pkg::LM_BREAK;
                        end else if (r_rx_count != '0) begin
                            res.irq_request = 1'b1;
                            n_link_mode     = islc_pkg::LM_BREAK;
                        end
                        // A slave slot fires only once per received break.
                        if (!i_cfg.master_mode) begin
                            n_timer_run = 1'b0;
                        end
                    end else begin
                        n_slot_count = cnt_inc;
                    end
                end
            end
            islc_pkg::ACT_EVENT: begin
                if (i_item.idle_seen && (r_rx_count != '0)) begin
                    ev = 1'b1;
                end
                // The break has gone out: start the burst or fall back to idle.
                if (r_link_mode == islc_pkg::LM_BREAK) begin
                    if (r_rx_count != '0) begin
                        ev = 1'b1;
                    end
                    if (r_tx_count != '0) begin
                        n_burst_on   = 1'b1;
                        n_burst_left = (cnt_cmp < w_cmp) ? islc_pkg::BURST_W'(cnt_cmp)
                                                         : islc_pkg::BURST_W'(w_cmp);
                        n_link_mode  = islc_pkg::LM_DATA;
                    end else begin
                        n_link_mode = islc_pkg::LM_IDLE;
                    end
                end
                if (i_item.break_seen) begin
                    if (!i_cfg.master_mode) begin
                        n_timer_run  = 1'b1;
                        n_slot_count = '0;
                        n_link_mode  = islc_pkg::LM_WAIT;
                    end
                end else if (i_item.rx_ready && !i_item.framing_error &&
                             (r_rx_count < islc_pkg::RX_CNT_W'(islc_pkg::RX_DEPTH))) begin
                    rx_req.we    = 1'b1;
                    rx_req.waddr = r_rx_tail;
                    rx_req.wdata = i_item.rx_byte;
                    n_rx_tail    = (r_rx_tail == islc_pkg::RX_PTR_W'(islc_pkg::RX_DEPTH - 1))
                                   ? '0 : r_rx_tail + islc_pkg::RX_PTR_W'(1);
                    n_rx_count   = r_rx_count + islc_pkg::RX_CNT_W'(1);
                end
                if (n_burst_on && i_item.tx_empty) begin
                    res.tx_valid = 1'b1;
                    if (r_tx_count != '0) begin
                        res.tx_pop   = 1'b1;
                        tx_req.re    = 1'b1;
                        tx_req.raddr = r_tx_head;
                        n_tx_head    = (r_tx_head == islc_pkg::TX_PTR_W'(islc_pkg::TX_DEPTH - 1))
                                       ? '0 : r_tx_head + islc_pkg::TX_PTR_W'(1);
                        n_tx_count   = r_tx_count - islc_pkg::TX_CNT_W'(1);
                    end
                    if (n_burst_left != '0) begin
                        n_burst_left = n_burst_left - islc_pkg::BURST_W'(1);
                    end
                    if ((n_burst_left == '0) || (n_tx_count == '0)) begin
                        n_burst_left = '0;
                        n_burst_on   = 1'b0;
                        n_link_mode  = islc_pkg::LM_IDLE;
                    end
                end
                res.notify = ev;
            end
            islc_pkg::ACT_WRITE: begin
                if (r_tx_count < islc_pkg::TX_CNT_W'(islc_pkg::TX_DEPTH)) begin
                    tx_req.we          = 1'b1;
                    tx_req.waddr       = r_tx_tail;
                    tx_req.wdata       = i_item.wr_byte;
                    n_tx_tail          = (r_tx_tail == islc_pkg::TX_PTR_W'(islc_pkg::TX_DEPTH - 1))
                                         ? '0 : r_tx_tail + islc_pkg::TX_PTR_W'(1);
                    n_tx_count         = r_tx_count + islc_pkg::TX_CNT_W'(1);
                    res.write_accepted = 1'b1;
                end
            end
            islc_pkg::ACT_READ: begin
                if (r_rx_count != '0) begin
                    res.rd_valid = 1'b1;
                    rx_req.re    = 1'b1;
                    rx_req.raddr = r_rx_head;
                    n_rx_head    = (r_rx_head == islc_pkg::RX_PTR_W'(islc_pkg::RX_DEPTH - 1))
                                   ? '0 : r_rx_head + islc_pkg::RX_PTR_W'(1);
                    n_rx_count   = r_rx_count - islc_pkg::RX_CNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        res.rx_level = islc_pkg::LEVEL_W'(n_rx_count);
        res.tx_level = islc_pkg::LEVEL_W'(n_tx_count);

        // Store accesses only happen for an accepted beat.
        rx_req.we = rx_req.we && i_accept;
        rx_req.re = rx_req.re && i_accept;
        tx_req.we = tx_req.we && i_accept;
        tx_req.re = tx_req.re && i_accept;
    end

    assign o_res    = res;
    assign o_rx_req = rx_req;
    assign o_tx_req = tx_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_mode  <= islc_pkg::LM_IDLE;
            r_burst_left <= '0;
            r_burst_on   <= 1'b0;
            r_timer_run  <= islc_pkg::MASTER_MODE_RESET;
            r_slot_count <= '0;
            r_rx_head    <= '0;
            r_rx_tail    <= '0;
            r_rx_count   <= '0;
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_tx_count   <= '0;
        end else if (i_cfg.master_wr) begin
            r_timer_run  <= i_cfg.master_mode;
            r_slot_count <= '0;
        end else if (i_accept) begin
            r_link_mode  <= n_link_mode;
            r_burst_left <= n_burst_left;
            r_burst_on   <= n_burst_on;
            r_timer_run  <= n_timer_run;
            r_slot_count <= n_slot_count;
            r_rx_head    <= n_rx_head;
            r_rx_tail    <= n_rx_tail;
            r_rx_count   <= n_rx_count;
            r_tx_head    <= n_tx_head;
            r_tx_tail    <= n_tx_tail;
            r_tx_count   <= n_tx_count;
        end
    end

endmodule

>>> hw/rtl/islc_out_pipe.sv
// Result pipeline: a stage that waits for the store read data and the output register.
// Depends on islc_pkg.
module islc_out_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  islc_pkg::t_ctl_res                  i_res,
    input  logic [islc_pkg::BYTE_W-1:0]         i_rx_rdata,
    input  logic [islc_pkg::BYTE_W-1:0]         i_tx_rdata,
    input  logic                                i_out_stall,
    output logic                                o_free,
    output logic                                o_out_valid,
    output islc_pkg::t_out_item                 o_out
);

    logic                 r_s1_valid, n_s1_valid;
    islc_pkg::t_ctl_res   r_s1;
    logic                 r_out_valid;
    islc_pkg::t_out_item  r_out, n_out;
    logic                 s1_adv;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_free     = !r_s1_valid || s1_adv;
    assign n_s1_valid = i_accept || (r_s1_valid && !s1_adv);

    // Store bytes come from the registered RAM read ports and are merged here.
    always_comb begin
        n_out                = '0;
        n_out.tx_valid       = r_s1.tx_valid;
        n_out.tx_byte        = r_s1.tx_pop ? i_tx_rdata : '0;
        n_out.send_break     = r_s1.send_break;
        n_out.notify         = r_s1.notify;
        n_out.irq_request    = r_s1.irq_request;
        n_out.write_accepted = r_s1.write_accepted;
        n_out.rd_valid       = r_s1.rd_valid;
        n_out.rd_byte        = r_s1.rd_valid ? i_rx_rdata : '0;
        n_out.rx_level       = r_s1.rx_level;
        n_out.tx_level       = r_s1.tx_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_res;
        end
        if (s1_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hw/rtl/infrared_slotted_link_controller_unit.sv
// Top level of the infrared slotted link controller: configuration registers, link control,
// the two byte stores and the result pipeline. Depends on islc_pkg and the islc_* modules.
//
// Use: every input beat carries one action (bit tick, serial event, host write byte or host
// read byte) and produces exactly one result beat with the transmit handoff, break request,
// notify pulse, irq request, host write and read status and both FIFO levels after the action.
// Both channels use valid/stall; a beat moves when valid is high and stall is low.
//
// Throughput is one beat per cycle while the output is not stalled. All link state (slot
// timer, link mode, burst state and FIFO pointers) sits in flops that update at the accept
// edge, so the next beat sees it at once. The receive and transmit bytes live in two
// synchronous RAMs with one write and one registered read port each; an item does at most one
// access per RAM, and a write is always visible to any later read, so no forwarding exists.
//
// Pipeline: the accept edge loads the middle stage and issues the RAM read; when the middle
// stage moves on, the read data is merged into the output register, which then holds the
// result beat as valid. While the receiver stalls, the output holds and one more beat is
// taken into the middle stage; after that the input stall rises, combinationally from the
// output stall.
//
// Reset (synchronous, active low) empties both FIFOs, sets the link idle and loads the
// register defaults: frame length 16, master mode on with its slot timer running. The RAM
// contents are not cleared; only written entries are ever read.
//
// Configuration: frame_length at byte address 0, master_mode at byte address 4; address bit 2
// selects the register. Writing master_mode restarts the slot count and sets the timer run
// state to the new mode. The user writes registers only while idle; the block does not check.
module infrared_slotted_link_controller_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  islc_pkg::t_in_item                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output islc_pkg::t_out_item                  o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [islc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [islc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [islc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [islc_pkg::FRAME_W-1:0] r_frame_length, n_frame_length;
    logic                         r_master_mode, n_master_mode;
    logic                         cfg_wr;
    islc_pkg::t_cfg               cfg;

    logic                         accept;
    logic                         pipe_free;
    islc_pkg::t_ctl_res           ctl_res;
    islc_pkg::t_rx_req            rx_req;
    islc_pkg::t_tx_req            tx_req;
    logic [islc_pkg::BYTE_W-1:0]  rx_rdata;
    logic [islc_pkg::BYTE_W-1:0]  tx_rdata;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_frame_length = r_frame_length;
        n_master_mode  = r_master_mode;
        if (cfg_wr) begin
            case (paddr[2])
                islc_pkg::REG_FRAME_LENGTH: n_frame_length = pwdata[islc_pkg::FRAME_W-1:0];
                islc_pkg::REG_MASTER_MODE:  n_master_mode  = pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= islc_pkg::FRAME_LENGTH_RESET;
            r_master_mode  <= islc_pkg::MASTER_MODE_RESET;
        end else begin
            r_frame_length <= n_frame_length;
            r_master_mode  <= n_master_mode;
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            islc_pkg::REG_FRAME_LENGTH: prdata = islc_pkg::APB_DATA_W'(r_frame_length);
            islc_pkg::REG_MASTER_MODE:  prdata = islc_pkg::APB_DATA_W'(r_master_mode);
            default: begin
            end
        endcase
    end

    // The link control sees a mode write at the edge that stores it, so the timer run
    // state it loads there is the new mode.
    assign cfg.frame_length = r_frame_length;
    assign cfg.master_mode  = n_master_mode;
    assign cfg.master_wr    = cfg_wr && (paddr[2] == islc_pkg::REG_MASTER_MODE);

    // A beat is taken whenever the middle stage is empty or moving on.
    assign accept     = i_in_valid && pipe_free;
    assign o_in_stall = !pipe_free;

    islc_link_ctl u_link_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .i_cfg    (cfg),
        .o_res    (ctl_res),
        .o_rx_req (rx_req),
        .o_tx_req (tx_req)
    );

    islc_ram #(
        .DEPTH (islc_pkg::RX_DEPTH),
        .WIDTH (islc_pkg::BYTE_W)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_req.we),
        .i_waddr (rx_req.waddr),
        .i_wdata (rx_req.wdata),
        .i_re    (rx_req.re),
        .i_raddr (rx_req.raddr),
        .o_rdata (rx_rdata)
    );

    islc_ram #(
        .DEPTH (islc_pkg::TX_DEPTH),
        .WIDTH (islc_pkg::BYTE_W)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_req.we),
        .i_waddr (tx_req.waddr),
        .i_wdata (tx_req.wdata),
        .i_re    (tx_req.re),
        .i_raddr (tx_req.raddr),
        .o_rdata (tx_rdata)
    );

    islc_out_pipe u_out_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_res       (ctl_res),
        .i_rx_rdata  (rx_rdata),
        .i_tx_rdata  (tx_rdata),
        .i_out_stall (i_out_stall),
        .o_free      (pipe_free),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

>>> hw/rtl/islc_checker.sv
// Port-level checks for the infrared slotted link controller, bound to its top level.
// Depends on islc_pkg.
module islc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input islc_pkg::t_out_item  o_out
);

    // No result beat right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    // A stalled result beat stays and keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

    // One action yields at most one kind of outcome.
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out.tx_valid || o_out.notify, o_out.send_break,
                                  o_out.irq_request, o_out.write_accepted, o_out.rd_valid}))
        else $error("result mixes outcomes of different actions");

    // Byte fields are zero when their valid flag is low.
    a_idle_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.tx_valid || (o_out.tx_byte == '0)) &&
                         (o_out.rd_valid || (o_out.rd_byte == '0))))
        else $error("byte field set without its valid flag");

    // Fill levels never exceed the FIFO depths.
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.rx_level <= islc_pkg::LEVEL_W'(islc_pkg::RX_DEPTH)) &&
                         (o_out.tx_level <= islc_pkg::LEVEL_W'(islc_pkg::TX_DEPTH))))
        else $error("fill level beyond FIFO depth");

endmodule

bind infrared_slotted_link_controller_unit islc_checker u_islc_checker (.*);

>>> bench/infrared_slotted_link_controller_unit_tb.sv
// Self-checking bench for the infrared slotted link controller: it drives action beats, predicts
// each result beat with its own model of the FIFOs, slot timer and burst logic, and compares.
// Depends on islc_pkg and infrared_slotted_link_controller_unit.
module infrared_slotted_link_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The bench gives up after this many cycles.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles the receiver holds off in one long stretch, enough to back up every stage.
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int IN_W = $bits(islc_pkg::t_in_item);

    // Serial event flags, packed in the order idle, break, rx_ready, framing_error, tx_empty.
    localparam logic [4:0] EV_IDLE    = 5'b10000;
    localparam logic [4:0] EV_BREAK   = 5'b01000;
    localparam logic [4:0] EV_RXRDY   = 5'b00100;
    localparam logic [4:0] EV_FRERR   = 5'b00010;
    localparam logic [4:0] EV_TXEMPTY = 5'b00001;

    // Clock, reset and every block input start at a known value.
    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    islc_pkg::t_in_item              in_beat    = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    islc_pkg::t_out_item             o_out;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [islc_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [islc_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [islc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    infrared_slotted_link_controller_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Beats waiting to be offered, and the result beats the link model says must come back.
    islc_pkg::t_in_item  pending_beats[$];
    islc_pkg::t_out_item due_results[$];

    // Idling controls, in percent, set by the stimulus between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The long hold-off is requested by the stimulus and served by the receiver process.
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int error_count = 0;
    int cycle_count = 0;

    // Link model state: configuration, link phase, burst, slot timer and both FIFOs.
    logic [islc_pkg::FRAME_W-1:0] cfg_frame  = islc_pkg::FRAME_LENGTH_RESET;
    logic                         cfg_master = islc_pkg::MASTER_MODE_RESET;
    islc_pkg::t_link_mode         link_state = islc_pkg::LM_IDLE;
    logic [islc_pkg::BURST_W-1:0] burst_left = '0;
    logic                         burst_on   = 1'b0;
    logic                         timer_on   = islc_pkg::MASTER_MODE_RESET;
    logic [islc_pkg::SLOT_W-1:0]  slot_cnt   = '0;
    logic [islc_pkg::BYTE_W-1:0]  rx_fifo[$];
    logic [islc_pkg::BYTE_W-1:0]  tx_fifo[$];

    // Burst width in bytes: the frame length held to the range 1..MAX_FRAME.
    function automatic int burst_width(input logic [islc_pkg::FRAME_W-1:0] frame);
        if (frame == '0) return 1;
        if (int'(frame) > islc_pkg::MAX_FRAME) return islc_pkg::MAX_FRAME;
        return int'(frame);
    endfunction

    // Bit ticks per slot. The master slot leaves room for a burst in each direction.
    function automatic int slot_ticks(input logic [islc_pkg::FRAME_W-1:0] frame,
                                      input logic master);
        int w;
        w = burst_width(frame);
        return master ? islc_pkg::BITS_PER_BYTE * (w + 2) * 2
                      : islc_pkg::BITS_PER_BYTE * (w + 1);
    endfunction

    // Advances the link model by one accepted beat and returns the result beat it implies.
    // Fields that do not belong to the action stay zero.
    function automatic islc_pkg::t_out_item link_step(input islc_pkg::t_in_item it);
        islc_pkg::t_out_item res;
        logic                unread;
        int                  w;
        res = '0;
        unread = 1'b0;
        case (islc_pkg::t_action'(it.action))
            islc_pkg::ACT_TICK: begin
                if (timer_on) begin
                    slot_cnt = slot_cnt + islc_pkg::SLOT_W'(1);
                    if (int'(slot_cnt) >= slot_ticks(cfg_frame, cfg_master)) begin
                        slot_cnt = '0;
                        if (cfg_master || tx_fifo.size() > 0) begin
                            res.send_break = 1'b1;
                            link_state = islc_pkg::LM_BREAK;
                        end else if (rx_fifo.size() > 0) begin
                            // A slave with only receive data asks for a flagless event instead.
                            link_state = islc_pkg::LM_BREAK;
                            res.irq_request = 1'b1;
                        end
                        // A slave fires once per received break.
                        if (!cfg_master) timer_on = 1'b0;
                    end
                end
            end
            islc_pkg::ACT_EVENT: begin
                if (it.idle_seen && rx_fifo.size() > 0) unread = 1'b1;
                // The first event after a break ends the break and may open a burst.
                if (link_state == islc_pkg::LM_BREAK) begin
                    if (rx_fifo.size() > 0) unread = 1'b1;
                    if (tx_fifo.size() > 0) begin
                        w = burst_width(cfg_frame);
                        burst_on = 1'b1;
                        burst_left = islc_pkg::BURST_W'((tx_fifo.size() < w) ?
                                                        tx_fifo.size() : w);
                        link_state = islc_pkg::LM_DATA;
                    end else begin
                        link_state = islc_pkg::LM_IDLE;
                    end
                end
                // A break on the line wins over a received byte, which is then lost.
                if (it.break_seen) begin
                    if (!cfg_master) begin
                        timer_on = 1'b1;
                        slot_cnt = '0;
                        link_state = islc_pkg::LM_WAIT;
                    end
                end else if (it.rx_ready && !it.framing_error &&
                             rx_fifo.size() < islc_pkg::RX_DEPTH) begin
                    rx_fifo.push_back(it.rx_byte);
                end
                if (burst_on && it.tx_empty) begin
                    res.tx_valid = 1'b1;
                    if (tx_fifo.size() > 0) res.tx_byte = tx_fifo.pop_front();
                    if (burst_left != '0) burst_left = burst_left - islc_pkg::BURST_W'(1);
                    if (burst_left == '0 || tx_fifo.size() == 0) begin
                        burst_left = '0;
                        burst_on = 1'b0;
                        link_state = islc_pkg::LM_IDLE;
                    end
                end
                res.notify = unread;
            end
            islc_pkg::ACT_WRITE: begin
                if (tx_fifo.size() < islc_pkg::TX_DEPTH) begin
                    tx_fifo.push_back(it.wr_byte);
                    res.write_accepted = 1'b1;
                end
            end
            default: begin
                if (rx_fifo.size() > 0) begin
                    res.rd_valid = 1'b1;
                    res.rd_byte = rx_fifo.pop_front();
                end
            end
        endcase
        res.rx_level = islc_pkg::LEVEL_W'(rx_fifo.size());
        res.tx_level = islc_pkg::LEVEL_W'(tx_fifo.size());
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endfunction

    // Driver. A beat moves at an edge where valid is high and stall is low; the link model
    // is stepped right there, so the expectations queue up in acceptance order. A new beat,
    // or a gap, is chosen only once the current beat has moved, so a stalled beat holds.
    always @(posedge i_clk) begin
        logic moved;
        if (i_rst_n) begin
            moved = i_in_valid && !o_in_stall;
            if (moved) due_results.push_back(link_step(in_beat));
            if (moved || !i_in_valid) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_beat <= pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver. Every result beat that moves is checked against the oldest
    // expectation. The stall for the next cycle comes from the long hold-off when one has
    // been requested, and otherwise from the phase's stall rate.
    always @(posedge i_clk) begin
        islc_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    error_count++;
                    $display("%0t ns: result beat with nothing expected, expected none, got 0x%0h",
                             $time, o_out);
                end else begin
                    want = due_results.pop_front();
                    check_field("tx_valid", 32'(want.tx_valid), 32'(o_out.tx_valid));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(o_out.tx_byte));
                    check_field("send_break", 32'(want.send_break), 32'(o_out.send_break));
                    check_field("notify", 32'(want.notify), 32'(o_out.notify));
                    check_field("irq_request", 32'(want.irq_request), 32'(o_out.irq_request));
                    check_field("write_accepted", 32'(want.write_accepted),
                                32'(o_out.write_accepted));
                    check_field("rd_valid", 32'(want.rd_valid), 32'(o_out.rd_valid));
                    check_field("rd_byte", 32'(want.rd_byte), 32'(o_out.rd_byte));
                    check_field("rx_level", 32'(want.rx_level), 32'(o_out.rx_level));
                    check_field("tx_level", 32'(want.tx_level), 32'(o_out.tx_level));
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d beats pending and %0d results outstanding",
                     $time, pending_beats.size(), due_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic islc_pkg::t_in_item beat(input islc_pkg::t_action act,
                                                input logic [4:0] flags,
                                                input logic [islc_pkg::BYTE_W-1:0] rx,
                                                input logic [islc_pkg::BYTE_W-1:0] wr);
        islc_pkg::t_in_item it;
        it.action = act;
        {it.idle_seen, it.break_seen, it.rx_ready, it.framing_error, it.tx_empty} = flags;
        it.rx_byte = rx;
        it.wr_byte = wr;
        return it;
    endfunction

    // Event flags with no break; a framing error shows up about one time in eight.
    function automatic logic [4:0] calm_flags();
        logic [4:0] f;
        f = 5'($urandom) & ~(EV_BREAK | EV_FRERR);
        if ($urandom_range(0, 7) == 0) f = f | EV_FRERR;
        return f;
    endfunction

    function automatic islc_pkg::t_in_item serial_beat(input logic [4:0] flags);
        return beat(islc_pkg::ACT_EVENT, flags, 8'($urandom), 8'($urandom));
    endfunction

    // A tick carries random bits in the fields it does not use.
    function automatic islc_pkg::t_in_item tick_beat();
        return beat(islc_pkg::ACT_TICK, 5'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic islc_pkg::t_in_item host_beat();
        return beat($urandom_range(0, 1) ? islc_pkg::ACT_WRITE : islc_pkg::ACT_READ,
                    5'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Fully random beat; a break is kept rare so that slave slots still get to fire.
    function automatic islc_pkg::t_in_item noise_beat();
        islc_pkg::t_in_item it;
        it = IN_W'($urandom);
        if ($urandom_range(0, 5) != 0) it.break_seen = 1'b0;
        return it;
    endfunction

    task automatic queue_noise(input int count);
        repeat (count) pending_beats.push_back(noise_beat());
    endtask

    // One well-formed slot: queue some bytes, receive a few, (slave) get synchronized by a
    // break, run the slot out tick by tick with host traffic mixed in, end the break with an
    // event, then burst out bytes and read back what came in.
    task automatic queue_slot(input logic slave, input int ticks);
        repeat ($urandom_range(0, 6)) pending_beats.push_back(beat(islc_pkg::ACT_WRITE,
                                                   5'($urandom), 8'($urandom), 8'($urandom)));
        repeat ($urandom_range(0, 3)) pending_beats.push_back(serial_beat(calm_flags() | EV_RXRDY));
        if (slave) pending_beats.push_back(serial_beat((calm_flags() & ~EV_TXEMPTY) | EV_BREAK));
        repeat (ticks) begin
            pending_beats.push_back(tick_beat());
            if ($urandom_range(0, 9) == 0) pending_beats.push_back(host_beat());
        end
        pending_beats.push_back(serial_beat(calm_flags()));
        repeat ($urandom_range(1, 8)) begin
            pending_beats.push_back(serial_beat(calm_flags() |
                                                ($urandom_range(0, 4) != 0 ? EV_TXEMPTY : 5'b0)));
        end
        repeat ($urandom_range(0, 3)) pending_beats.push_back(beat(islc_pkg::ACT_READ,
                                                  5'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    // Fills the transmit FIFO and the receive FIFO past full, then reads past empty.
    task automatic queue_fill();
        repeat (islc_pkg::TX_DEPTH + 4) pending_beats.push_back(beat(islc_pkg::ACT_WRITE,
                                                    5'($urandom), 8'($urandom), 8'($urandom)));
        repeat (islc_pkg::RX_DEPTH + 4) pending_beats.push_back(serial_beat(EV_RXRDY |
                                                    (5'($urandom) & (EV_IDLE | EV_TXEMPTY))));
        repeat (islc_pkg::RX_DEPTH + 4) pending_beats.push_back(beat(islc_pkg::ACT_READ,
                                                    5'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    // Returns once every beat has been offered, accepted and answered. Each beat yields
    // exactly one result, so an empty expectation queue means the block holds no work.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || due_results.size() != 0);
    endtask

    // Configuration write: setup cycle, then access cycle. pready is tied high, so the
    // register takes the value at the edge that ends the access cycle.
    task automatic write_reg(input logic sel, input logic [islc_pkg::APB_DATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == islc_pkg::REG_FRAME_LENGTH) begin
            cfg_frame = value[islc_pkg::FRAME_W-1:0];
        end else begin
            // Changing the mode restarts the slot count and sets whether the timer runs.
            cfg_master = value[0];
            timer_on = value[0];
            slot_cnt = '0;
        end
        @(negedge i_clk);
    endtask

    task automatic set_phase(input logic [islc_pkg::FRAME_W-1:0] frame, input logic master,
                             input int idle_pct, input int stall_pct);
        write_reg(islc_pkg::REG_FRAME_LENGTH, islc_pkg::APB_DATA_W'(frame));
        write_reg(islc_pkg::REG_MASTER_MODE, islc_pkg::APB_DATA_W'(master));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats at the reset configuration (master, frame length 16).
        // Reading the empty receive FIFO returns nothing.
        pending_beats.push_back(beat(islc_pkg::ACT_READ, 5'b0, 8'h00, 8'h00));
        pending_beats.push_back(beat(islc_pkg::ACT_WRITE, 5'b0, 8'h00, 8'h00));
        pending_beats.push_back(beat(islc_pkg::ACT_WRITE, 5'b0, 8'h00, 8'hFF));
        // Flags and the received byte mean nothing to a host write.
        pending_beats.push_back(beat(islc_pkg::ACT_WRITE, 5'b11111, 8'hFF, 8'h5A));
        pending_beats.push_back(beat(islc_pkg::ACT_EVENT, EV_RXRDY, 8'hFF, 8'h00));
        pending_beats.push_back(beat(islc_pkg::ACT_EVENT, EV_RXRDY, 8'h00, 8'hFF));
        // A byte with a framing error is dropped.
        pending_beats.push_back(beat(islc_pkg::ACT_EVENT, EV_RXRDY | EV_FRERR, 8'h5A, 8'h00));
        // The master ignores a received break, and the byte that came with it is lost.
        pending_beats.push_back(beat(islc_pkg::ACT_EVENT, EV_BREAK | EV_RXRDY, 8'hA5, 8'h00));
        // Line idle with unread data raises notify.
        pending_beats.push_back(beat(islc_pkg::ACT_EVENT, EV_IDLE, 8'h00, 8'h00));
        // Transmitter ready outside a burst hands over nothing.
        pending_beats.push_back(beat(islc_pkg::ACT_EVENT, EV_TXEMPTY, 8'h00, 8'h00));
        pending_beats.push_back(beat(islc_pkg::ACT_EVENT, 5'b11111, 8'hFF, 8'hFF));
        pending_beats.push_back(beat(islc_pkg::ACT_TICK, 5'b11111, 8'hFF, 8'hFF));
        pending_beats.push_back(beat(islc_pkg::ACT_TICK, 5'b0, 8'h00, 8'h00));
        repeat (3) pending_beats.push_back(beat(islc_pkg::ACT_READ, 5'b11111, 8'hFF, 8'hFF));
        // With the receive FIFO empty again, line idle stays quiet.
        pending_beats.push_back(beat(islc_pkg::ACT_EVENT, EV_IDLE, 8'h00, 8'h00));
        wait_drained();

        // Master with the shortest slot, no idling on either side.
        set_phase(islc_pkg::FRAME_W'(1), 1'b1, 0, 0);
        repeat (3) queue_slot(1'b0, slot_ticks(islc_pkg::FRAME_W'(1), 1'b1));
        wait_drained();

        // Frame length zero acts as one; the sender idles most of the time.
        set_phase(islc_pkg::FRAME_W'(0), 1'b1, 78, 0);
        repeat (3) queue_slot(1'b0, slot_ticks(islc_pkg::FRAME_W'(0), 1'b1));
        queue_noise(40);
        wait_drained();

        // Slave slots started by received breaks; the receiver stalls most of the time.
        set_phase(islc_pkg::FRAME_W'(2), 1'b0, 0, 78);
        repeat (5) queue_slot(1'b1, slot_ticks(islc_pkg::FRAME_W'(2), 1'b0));
        queue_noise(30);
        wait_drained();

        // Both FIFOs past full and the receive FIFO read past empty, then slave slots with a
        // full transmit FIFO; light idling on both sides.
        set_phase(islc_pkg::FRAME_W'(1), 1'b0, 14, 14);
        queue_fill();
        repeat (3) queue_slot(1'b1, slot_ticks(islc_pkg::FRAME_W'(1), 1'b0));
        wait_drained();

        // Widest frame. The receiver holds off for a long stretch while the sender keeps
        // offering beats, so the block backs up and stalls its input.
        set_phase(islc_pkg::FRAME_W'(islc_pkg::MAX_FRAME), 1'b1, 0, 0);
        queue_noise(80);
        hold_requests = hold_requests + 1;
        wait_drained();

        // A slave slot fires with a full transmit FIFO, then the frame length goes to its
        // top value before the break ends: the burst is held to MAX_FRAME bytes.
        set_phase(islc_pkg::FRAME_W'(1), 1'b0, 14, 0);
        repeat (islc_pkg::TX_DEPTH) pending_beats.push_back(beat(islc_pkg::ACT_WRITE,
                                                   5'($urandom), 8'($urandom), 8'($urandom)));
        pending_beats.push_back(serial_beat((calm_flags() & ~EV_TXEMPTY) | EV_BREAK));
        repeat (slot_ticks(islc_pkg::FRAME_W'(1), 1'b0)) pending_beats.push_back(tick_beat());
        wait_drained();
        write_reg(islc_pkg::REG_FRAME_LENGTH, islc_pkg::APB_DATA_W'(7'h7F));
        repeat (islc_pkg::TX_DEPTH + 7) begin
            pending_beats.push_back(serial_beat(calm_flags() | EV_TXEMPTY));
        end
        wait_drained();

        // Mid-size master slot with random traffic around it.
        set_phase(islc_pkg::FRAME_W'(3), 1'b1, 14, 14);
        queue_slot(1'b0, slot_ticks(islc_pkg::FRAME_W'(3), 1'b1));
        queue_noise(60);
        wait_drained();

        // Run on in case a stray result beat follows the last one.
        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0) begin
            error_count++;
            $display("%0t ns: results left over, expected 0 outstanding, got %0d",
                     $time, due_results.size());
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> infrared_slotted_link_controller_unit.f
hw/rtl/islc_pkg.sv
hw/rtl/islc_ram.sv
hw/rtl/islc_link_ctl.sv
hw/rtl/islc_out_pipe.sv
hw/rtl/infrared_slotted_link_controller_unit.sv
hw/rtl/islc_checker.sv
bench/infrared_slotted_link_controller_unit_tb.sv
